// ----- rtl/nh_pkg.sv -----
package nh_pkg;

    localparam int MAX_GROUPS_DEF = 64;
    localparam int KEY_WORDS_DEF  = 268;
    localparam int PASSES         = 4;
    localparam int LANES          = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QLVL_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W          = 7;
    localparam int ROW_W          = 7;

    localparam logic FUNC_KEY = 1'b0;
    localparam logic FUNC_MSG = 1'b1;

    typedef logic [31:0] word_t;
    typedef logic [LANES-1:0][31:0] row_t;

    // one queued beat: either a key word write or a message group with its new key row
    typedef struct packed {
        logic             is_msg;
        logic             last;
        logic             drop;
        logic [POS_W-1:0] pos;
        logic [ROW_W-1:0] wr_row;
        logic [1:0]       wr_lane;
        word_t            wr_word;
        row_t             msg;
        row_t             key_row;
    } nh_entry_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              empty;
        logic              full;
    } nh_qstat_t;

endpackage

// ----- rtl/nh_universal_hash_core.sv -----
// path: a last group moves through f2, a queue slot, b1, b2, b3 and the output register
// throughput: one beat per cycle unless stalled, key writes and message groups alike;
//   key store: one 4-word row per cycle; the four passes run 8 parallel 32x32 multipliers
// reset: rst_n async, clears group count, pass sums, overrun flag, queue and valids;
//   the key store is not cleared and must be loaded before use
module nh_universal_hash_core #(
    parameter int MAX_GROUPS = nh_pkg::MAX_GROUPS_DEF,
    parameter int KEY_WORDS  = nh_pkg::KEY_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [8:0]  key_addr,
    input  logic [31:0] key_word,
    input  logic [63:0] msg_lo,
    input  logic [63:0] msg_hi,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] sum0,
    output logic [63:0] sum1,
    output logic [63:0] sum2,
    output logic [63:0] sum3,
    output logic        overrun
);
    import nh_pkg::*;

    logic      push;
    logic      pop;
    nh_entry_t push_entry;
    nh_entry_t head;
    nh_qstat_t q_stat;

    nh_front #(
        .MAX_GROUPS(MAX_GROUPS),
        .KEY_WORDS (KEY_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key_addr  (key_addr),
        .key_word  (key_word),
        .msg_lo    (msg_lo),
        .msg_hi    (msg_hi),
        .last      (last),
        .q_stat    (q_stat),
        .push      (push),
        .push_entry(push_entry)
    );

    nh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    nh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sum0     (sum0),
        .sum1     (sum1),
        .sum2     (sum2),
        .sum3     (sum3),
        .overrun  (overrun)
    );

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> in_stall)
        else $error("input not stalled with queue full");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("front pushed into a full queue");

endmodule

// ----- rtl/nh_front.sv -----
module nh_front #(
    parameter int MAX_GROUPS = nh_pkg::MAX_GROUPS_DEF,
    parameter int KEY_WORDS  = nh_pkg::KEY_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [8:0]        key_addr,
    input  logic [31:0]       key_word,
    input  logic [63:0]       msg_lo,
    input  logic [63:0]       msg_hi,
    input  logic              last,
    input  nh_pkg::nh_qstat_t q_stat,
    output logic              push,
    output nh_pkg::nh_entry_t push_entry
);
    import nh_pkg::*;

    localparam int ROWS   = (KEY_WORDS + 3) / 4;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int SW     = QLVL_W + 1;

    row_t key_mem [ROWS];

    logic             accept;
    logic             is_msg;
    logic             key_wr;
    logic             drop;
    logic [7:0]       rd_row;
    logic             rd_ok;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic             f2_valid_reg;
    logic             f2_valid_next;
    nh_entry_t        f2_entry_reg;
    logic             f2_rd_ok_reg;
    logic [7:0]       f2_rd_row_reg;
    row_t             rd_data_reg;

    // credit check on registered terms only, so the stage in flight always finds room
    assign in_stall = (SW'(q_stat.level) + SW'(f2_valid_reg)) >= SW'(QUEUE_DEPTH);
    assign accept   = in_valid && !in_stall;
    assign is_msg   = (func == FUNC_MSG);
    assign key_wr   = accept && (func == FUNC_KEY) && (key_addr < 9'(KEY_WORDS));
    assign drop     = !(pos_reg < POS_W'(MAX_GROUPS));

    // group g needs key rows g..g+3; only row g+3 is new to the sliding window
    assign rd_row = 8'(pos_reg) + 8'd3;
    assign rd_ok  = rd_row < 8'(ROWS);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept && is_msg)
        begin
            if (last)
                pos_next = '0;
            else if (!drop)
                pos_next = pos_reg + POS_W'(1);
        end
    end

    assign f2_valid_next = accept && (is_msg || key_wr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
            key_mem[key_addr[ROW_AW+1:2]][key_addr[1:0]] <= key_word;
        if (accept && is_msg && rd_ok)
            rd_data_reg <= key_mem[rd_row[ROW_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f2_entry_reg.is_msg  <= is_msg;
            f2_entry_reg.last    <= last;
            f2_entry_reg.drop    <= drop;
            f2_entry_reg.pos     <= pos_reg;
            f2_entry_reg.wr_row  <= key_addr[8:2];
            f2_entry_reg.wr_lane <= key_addr[1:0];
            f2_entry_reg.wr_word <= key_word;
            f2_entry_reg.msg     <= {msg_hi, msg_lo};
            f2_entry_reg.key_row <= '0;
            f2_rd_ok_reg         <= rd_ok;
            f2_rd_row_reg        <= rd_row;
        end
    end

    // words past the end of the key read as zero
    always_comb
    begin
        push_entry = f2_entry_reg;
        for (int j = 0; j < LANES; j++)
        begin
            if (f2_rd_ok_reg && (({f2_rd_row_reg, 2'b00} + 10'(j)) < 10'(KEY_WORDS)))
                push_entry.key_row[j] = rd_data_reg[j];
            else
                push_entry.key_row[j] = '0;
        end
    end

    assign push = f2_valid_reg;

endmodule

// ----- rtl/nh_queue.sv -----
module nh_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nh_pkg::nh_entry_t push_entry,
    input  logic              pop,
    output nh_pkg::nh_entry_t head,
    output nh_pkg::nh_qstat_t q_stat
);
    import nh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    nh_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [QLVL_W-1:0] level_reg;
    logic [QLVL_W-1:0] level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            level_next = level_reg + QLVL_W'(1);
        else if (pop && !push)
            level_next = level_reg - QLVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.level = level_reg;
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.full  = (level_reg == QLVL_W'(QUEUE_DEPTH));

endmodule

// ----- rtl/nh_back.sv -----
module nh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  nh_pkg::nh_entry_t head,
    input  nh_pkg::nh_qstat_t q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       sum0,
    output logic [63:0]       sum1,
    output logic [63:0]       sum2,
    output logic [63:0]       sum3,
    output logic              overrun
);
    import nh_pkg::*;

    logic enable;

    // key rows 0..3 for the first group, and the window of rows g-1..g+2
    row_t             low_reg [4];
    row_t             win_reg [4];
    logic [POS_W-1:0] win_base_reg;
    row_t             win_sel [4];
    row_t             add_next [PASSES];

    row_t        b1_a_reg [PASSES];
    logic        b1_valid_reg;
    logic        b1_add_reg;
    logic        b1_drop_reg;
    logic        b1_last_reg;

    logic [63:0] b2_prod_reg [PASSES][2];
    logic        b2_valid_reg;
    logic        b2_add_reg;
    logic        b2_drop_reg;
    logic        b2_last_reg;

    logic [63:0] b3_s_reg [PASSES];
    logic        b3_valid_reg;
    logic        b3_add_reg;
    logic        b3_drop_reg;
    logic        b3_last_reg;

    logic [63:0] acc_reg [PASSES];
    logic [63:0] acc_next [PASSES];
    logic        ov_reg;
    logic        ov_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_sum_reg [PASSES];
    logic        out_ov_reg;

    // the whole back pipeline moves together, held only by a full, stalled output
    assign enable = !out_valid_reg || !out_stall;
    assign pop    = enable && !q_stat.empty;

    always_comb
    begin
        if (head.pos == '0)
        begin
            win_sel[0] = low_reg[0];
            win_sel[1] = low_reg[1];
            win_sel[2] = low_reg[2];
            win_sel[3] = low_reg[3];
        end
        else
        begin
            win_sel[0] = win_reg[1];
            win_sel[1] = win_reg[2];
            win_sel[2] = win_reg[3];
            win_sel[3] = head.key_row;
        end
        for (int p = 0; p < PASSES; p++)
        begin
            for (int j = 0; j < LANES; j++)
                add_next[p][j] = head.msg[j] + win_sel[p][j];
        end
    end

    // window and low rows follow key writes in stream order
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head.is_msg)
            begin
                if (!head.drop)
                begin
                    win_reg      <= win_sel;
                    win_base_reg <= head.pos;
                end
                b1_a_reg <= add_next;
            end
            else
            begin
                if (head.wr_row < ROW_W'(4))
                    low_reg[head.wr_row[1:0]][head.wr_lane] <= head.wr_word;
                for (int i = 0; i < 4; i++)
                begin
                    if (8'(head.wr_row) == 8'(win_base_reg) + 8'(i))
                        win_reg[i][head.wr_lane] <= head.wr_word;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int p = 0; p < PASSES; p++)
            begin
                b2_prod_reg[p][0] <= 64'(b1_a_reg[p][0]) * 64'(b1_a_reg[p][2]);
                b2_prod_reg[p][1] <= 64'(b1_a_reg[p][1]) * 64'(b1_a_reg[p][3]);
                b3_s_reg[p]       <= b2_prod_reg[p][0] + b2_prod_reg[p][1];
            end
        end
    end

    always_comb
    begin
        for (int p = 0; p < PASSES; p++)
            acc_next[p] = acc_reg[p] + (b3_add_reg ? b3_s_reg[p] : 64'd0);
        ov_next = ov_reg || b3_drop_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (enable)
            out_valid_next = b3_valid_reg && b3_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b1_add_reg    <= 1'b0;
            b1_drop_reg   <= 1'b0;
            b1_last_reg   <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b2_add_reg    <= 1'b0;
            b2_drop_reg   <= 1'b0;
            b2_last_reg   <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b3_add_reg    <= 1'b0;
            b3_drop_reg   <= 1'b0;
            b3_last_reg   <= 1'b0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PASSES; p++)
                acc_reg[p] <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (enable)
            begin
                b1_valid_reg <= pop && head.is_msg;
                b1_add_reg   <= pop && head.is_msg && !head.drop;
                b1_drop_reg  <= head.drop;
                b1_last_reg  <= head.last;
                b2_valid_reg <= b1_valid_reg;
                b2_add_reg   <= b1_add_reg;
                b2_drop_reg  <= b1_drop_reg;
                b2_last_reg  <= b1_last_reg;
                b3_valid_reg <= b2_valid_reg;
                b3_add_reg   <= b2_add_reg;
                b3_drop_reg  <= b2_drop_reg;
                b3_last_reg  <= b2_last_reg;
                if (b3_valid_reg)
                begin
                    if (b3_last_reg)
                    begin
                        ov_reg <= 1'b0;
                        for (int p = 0; p < PASSES; p++)
                            acc_reg[p] <= '0;
                    end
                    else
                    begin
                        ov_reg  <= ov_next;
                        acc_reg <= acc_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && b3_valid_reg && b3_last_reg)
        begin
            out_sum_reg <= acc_next;
            out_ov_reg  <= ov_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum0      = out_sum_reg[0];
    assign sum1      = out_sum_reg[1];
    assign sum2      = out_sum_reg[2];
    assign sum3      = out_sum_reg[3];
    assign overrun   = out_ov_reg;

endmodule
